// ===== sv/cpm_pkg.sv =====
// Shared types, codes and constants of the control-pilot monitor.
`default_nettype none

package cpm_pkg;

    // Field widths
    localparam int VOLT_W  = 12;
    localparam int TICK_W  = 4;
    localparam int CLASS_W = 3;
    localparam int STATE_W = 3;
    localparam int EVENT_W = 4;
    localparam int INDEX_W = 3;

    // Fixed abnormal-zone bounds, 10 mV units
    localparam logic [VOLT_W-1:0] ZONE_LOW  = 12'd200;
    localparam logic [VOLT_W-1:0] ZONE_HIGH = 12'd1320;
    localparam logic [VOLT_W-1:0] GAP1_LOW  = 12'd720;
    localparam logic [VOLT_W-1:0] GAP1_HIGH = 12'd780;
    localparam logic [VOLT_W-1:0] GAP2_LOW  = 12'd1020;
    localparam logic [VOLT_W-1:0] GAP2_HIGH = 12'd1080;

    // Register reset values
    localparam logic [VOLT_W-1:0] LEVEL12_MIN_RST  = 12'd1080;
    localparam logic [VOLT_W-1:0] LEVEL12_MAX_RST  = 12'd1320;
    localparam logic [VOLT_W-1:0] LEVEL9_MIN_RST   = 12'd780;
    localparam logic [VOLT_W-1:0] LEVEL9_MAX_RST   = 12'd1020;
    localparam logic [VOLT_W-1:0] LEVEL6_MIN_RST   = 12'd480;
    localparam logic [VOLT_W-1:0] LEVEL6_MAX_RST   = 12'd720;
    localparam logic [TICK_W-1:0] IGNORE_TICKS_RST = 4'd6;

    // Register indexes
    localparam logic [INDEX_W-1:0] REG_LEVEL12_MIN  = 3'd0;
    localparam logic [INDEX_W-1:0] REG_LEVEL12_MAX  = 3'd1;
    localparam logic [INDEX_W-1:0] REG_LEVEL9_MIN   = 3'd2;
    localparam logic [INDEX_W-1:0] REG_LEVEL9_MAX   = 3'd3;
    localparam logic [INDEX_W-1:0] REG_LEVEL6_MIN   = 3'd4;
    localparam logic [INDEX_W-1:0] REG_LEVEL6_MAX   = 3'd5;
    localparam logic [INDEX_W-1:0] REG_IGNORE_TICKS = 3'd6;

    // Pilot class codes
    localparam logic [CLASS_W-1:0] CLS_UNKNOWN = 3'd0;
    localparam logic [CLASS_W-1:0] CLS_12_DC   = 3'd1;
    localparam logic [CLASS_W-1:0] CLS_12_PWM  = 3'd2;
    localparam logic [CLASS_W-1:0] CLS_9_DC    = 3'd3;
    localparam logic [CLASS_W-1:0] CLS_9_PWM   = 3'd4;
    localparam logic [CLASS_W-1:0] CLS_6_DC    = 3'd5;
    localparam logic [CLASS_W-1:0] CLS_6_PWM   = 3'd6;

    // Charge state codes
    localparam logic [STATE_W-1:0] CHG_UNPLUGGED  = 3'd0;
    localparam logic [STATE_W-1:0] CHG_PLUGGED    = 3'd1;
    localparam logic [STATE_W-1:0] CHG_EV_READY   = 3'd2;
    localparam logic [STATE_W-1:0] CHG_EVSE_READY = 3'd3;
    localparam logic [STATE_W-1:0] CHG_CHARGING   = 3'd4;
    localparam logic [STATE_W-1:0] CHG_ERROR      = 3'd5;

    // Event codes
    localparam logic [EVENT_W-1:0] EV_NONE       = 4'd0;
    localparam logic [EVENT_W-1:0] EV_PLUGIN     = 4'd1;
    localparam logic [EVENT_W-1:0] EV_PLUGOUT    = 4'd2;
    localparam logic [EVENT_W-1:0] EV_EV_READY   = 4'd3;
    localparam logic [EVENT_W-1:0] EV_EVSE_READY = 4'd4;
    localparam logic [EVENT_W-1:0] EV_START      = 4'd5;
    localparam logic [EVENT_W-1:0] EV_PAUSE      = 4'd6;
    localparam logic [EVENT_W-1:0] EV_ERROR      = 4'd7;
    localparam logic [EVENT_W-1:0] EV_RECOVERY   = 4'd8;

    // Input transaction
    typedef struct packed {
        logic [VOLT_W-1:0] sample_voltage;
        logic              pwm_on;
    } cpm_in_t;

    // Result transaction
    typedef struct packed {
        logic [VOLT_W-1:0]  clean_voltage;
        logic [CLASS_W-1:0] pilot_class;
        logic [STATE_W-1:0] charge_state;
        logic [EVENT_W-1:0] event_code;
    } cpm_out_t;

    // Class window settings handed to the classifier
    typedef struct packed {
        logic [VOLT_W-1:0] level12_min;
        logic [VOLT_W-1:0] level12_max;
        logic [VOLT_W-1:0] level9_min;
        logic [VOLT_W-1:0] level9_max;
        logic [VOLT_W-1:0] level6_min;
        logic [VOLT_W-1:0] level6_max;
    } cpm_levels_t;

endpackage

`default_nettype wire

// ===== sv/cpm_filter.sv =====
// Glitch filter: holds the last voltage over the first abnormal sample and the ignore_ticks samples after it.
`default_nettype none

module cpm_filter (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       step,
    input  wire logic [cpm_pkg::VOLT_W-1:0] sample_voltage,
    input  wire logic [cpm_pkg::TICK_W-1:0] ignore_ticks,
    output logic      [cpm_pkg::VOLT_W-1:0] clean_voltage
);
    import cpm_pkg::*;

    logic [TICK_W-1:0] skip_count_reg;
    logic [TICK_W-1:0] skip_count_next;
    logic [VOLT_W-1:0] held_voltage_reg;
    logic [VOLT_W-1:0] held_voltage_next;
    logic              abnormal_reg;
    logic              abnormal_next;
    logic              in_zone;

    // Flag samples outside the normal pilot levels
    assign in_zone = (sample_voltage < ZONE_LOW) || (sample_voltage > ZONE_HIGH)
                  || ((sample_voltage > GAP1_LOW) && (sample_voltage < GAP1_HIGH))
                  || ((sample_voltage > GAP2_LOW) && (sample_voltage < GAP2_HIGH));

    // Skip, hold or pass the sample
    always_comb
    begin
        skip_count_next   = skip_count_reg;
        held_voltage_next = held_voltage_reg;
        abnormal_next     = abnormal_reg;
        clean_voltage     = sample_voltage;
        if (skip_count_reg != '0)
        begin
            skip_count_next = skip_count_reg - 1'b1;
            clean_voltage   = held_voltage_reg;
        end
        else if (in_zone)
        begin
            if (!abnormal_reg)
            begin
                abnormal_next   = 1'b1;
                skip_count_next = ignore_ticks;
                clean_voltage   = held_voltage_reg;
            end
            else
            begin
                held_voltage_next = sample_voltage;
            end
        end
        else
        begin
            abnormal_next     = 1'b0;
            held_voltage_next = sample_voltage;
        end
    end

    // Advance filter state once per transaction
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            skip_count_reg   <= '0;
            held_voltage_reg <= '0;
            abnormal_reg     <= 1'b0;
        end
        else if (step)
        begin
            skip_count_reg   <= skip_count_next;
            held_voltage_reg <= held_voltage_next;
            abnormal_reg     <= abnormal_next;
        end
    end

endmodule

`default_nettype wire

// ===== sv/cpm_classify.sv =====
// Pilot level classifier: 12, 9 or 6 V, DC or PWM, or unknown.
`default_nettype none

module cpm_classify (
    input  wire logic [cpm_pkg::VOLT_W-1:0]  voltage,
    input  wire logic                        pwm_on,
    input  wire cpm_pkg::cpm_levels_t        levels,
    output logic      [cpm_pkg::CLASS_W-1:0] pilot_class
);
    import cpm_pkg::*;

    logic hit12;
    logic hit9;
    logic hit6;

    // Test each window; an empty window never matches
    assign hit12 = (voltage >= levels.level12_min) && (voltage <= levels.level12_max);
    assign hit9  = (voltage >= levels.level9_min)  && (voltage <= levels.level9_max);
    assign hit6  = (voltage >= levels.level6_min)  && (voltage <= levels.level6_max);

    // Give 12 V priority, then 9 V, then 6 V
    always_comb
    begin
        if (hit12)
            pilot_class = pwm_on ? CLS_12_PWM : CLS_12_DC;
        else if (hit9)
            pilot_class = pwm_on ? CLS_9_PWM : CLS_9_DC;
        else if (hit6)
            pilot_class = pwm_on ? CLS_6_PWM : CLS_6_DC;
        else
            pilot_class = CLS_UNKNOWN;
    end

endmodule

`default_nettype wire

// ===== sv/cpm_fsm.sv =====
// Plug and charge state machine driven by the pilot class.
`default_nettype none

module cpm_fsm (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        step,
    input  wire logic [cpm_pkg::CLASS_W-1:0] pilot_class,
    output logic      [cpm_pkg::STATE_W-1:0] charge_state,
    output logic      [cpm_pkg::EVENT_W-1:0] event_code
);
    import cpm_pkg::*;

    typedef enum logic [STATE_W-1:0] {
        S_UNPLUGGED  = CHG_UNPLUGGED,
        S_PLUGGED    = CHG_PLUGGED,
        S_EV_READY   = CHG_EV_READY,
        S_EVSE_READY = CHG_EVSE_READY,
        S_CHARGING   = CHG_CHARGING,
        S_ERROR      = CHG_ERROR
    } plug_state_t;

    plug_state_t state_reg;
    plug_state_t state_next;
    logic        is12;

    assign is12 = (pilot_class == CLS_12_DC) || (pilot_class == CLS_12_PWM);

    // Next state and event for this transaction
    always_comb
    begin
        state_next = state_reg;
        event_code = EV_NONE;
        if (pilot_class == CLS_UNKNOWN)
        begin
            state_next = S_ERROR;
            event_code = EV_ERROR;
        end
        else
        begin
            case (state_reg)
                S_UNPLUGGED:
                begin
                    if ((pilot_class == CLS_9_DC) || (pilot_class == CLS_6_DC))
                    begin
                        state_next = S_PLUGGED;
                        event_code = EV_PLUGIN;
                    end
                end
                S_PLUGGED:
                begin
                    if (pilot_class == CLS_6_DC)
                    begin
                        state_next = S_EV_READY;
                        event_code = EV_EV_READY;
                    end
                    else if (pilot_class == CLS_9_PWM)
                    begin
                        state_next = S_EVSE_READY;
                        event_code = EV_EVSE_READY;
                    end
                    else if (pilot_class == CLS_6_PWM)
                    begin
                        state_next = S_CHARGING;
                        event_code = EV_START;
                    end
                    else if (is12)
                    begin
                        state_next = S_UNPLUGGED;
                        event_code = EV_PLUGOUT;
                    end
                end
                S_EV_READY, S_EVSE_READY:
                begin
                    if (pilot_class == CLS_6_PWM)
                    begin
                        state_next = S_CHARGING;
                        event_code = EV_START;
                    end
                    else if (pilot_class == CLS_9_DC)
                    begin
                        state_next = S_PLUGGED;
                    end
                    else if (is12)
                    begin
                        state_next = S_UNPLUGGED;
                        event_code = EV_PLUGOUT;
                    end
                end
                S_CHARGING:
                begin
                    if (pilot_class == CLS_9_PWM)
                    begin
                        state_next = S_EVSE_READY;
                        event_code = EV_PAUSE;
                    end
                    else if (pilot_class == CLS_6_DC)
                    begin
                        state_next = S_EV_READY;
                    end
                    else if (is12)
                    begin
                        state_next = S_UNPLUGGED;
                        event_code = EV_PLUGOUT;
                    end
                end
                S_ERROR:
                begin
                    state_next = is12 ? S_UNPLUGGED : S_PLUGGED;
                    event_code = EV_RECOVERY;
                end
                default:
                begin
                    state_next = state_reg;
                end
            endcase
        end
    end

    assign charge_state = state_next;

    // Hold plug state, advance once per transaction
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_UNPLUGGED;
        else if (step)
            state_reg <= state_next;
    end

endmodule

`default_nettype wire

// ===== sv/ev_control_pilot_monitor.sv =====
// Control-pilot monitor top level: registers, handshakes and datapath wiring.
//
// Usage:
//   Input channel (item_valid/item_ready/item) takes one pilot sample and the
//   PWM flag per transaction. Result channel (result_valid/result_ready/result)
//   returns one transaction per input: filtered voltage, pilot class, charge
//   state after the tick and the event code.
//   Configuration channel (cfg_valid/cfg_ready/cfg_index/cfg_data) writes the
//   class windows (index 0..5) and the skip count (index 6); index 7 is
//   ignored. cfg_ready is always high. Write only while no transaction is in
//   flight.
//   An accepted input sits in the input register; the result register loads
//   from it once the result register is free or being read.
//   Throughput: one transaction per cycle unless the receiver stalls; filter,
//   classifier and state machine settle in the single stage between registers.
//   Reset clears the filter state, sets the plug state to unplugged and loads
//   the default class windows and skip count.
//   When the receiver stalls, the result register holds; the input register
//   fills, and item_ready drops only when both are full.
`default_nettype none

module ev_control_pilot_monitor (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        item_valid,
    output logic                             item_ready,
    input  wire cpm_pkg::cpm_in_t            item,
    output logic                             result_valid,
    input  wire logic                        result_ready,
    output cpm_pkg::cpm_out_t                result,
    input  wire logic                        cfg_valid,
    output logic                             cfg_ready,
    input  wire logic [cpm_pkg::INDEX_W-1:0] cfg_index,
    input  wire logic [cpm_pkg::VOLT_W-1:0]  cfg_data
);
    import cpm_pkg::*;

    cpm_levels_t        levels_reg;
    logic [TICK_W-1:0]  ignore_ticks_reg;
    logic               stage_valid_reg;
    cpm_in_t            stage_reg;
    logic               out_valid_reg;
    cpm_out_t           out_reg;
    cpm_out_t           out_next;
    logic               advance;
    logic [VOLT_W-1:0]  clean_voltage;
    logic [CLASS_W-1:0] pilot_class;
    logic [STATE_W-1:0] charge_state;
    logic [EVENT_W-1:0] event_code;

    // Handshake control
    assign cfg_ready    = 1'b1;
    assign advance      = stage_valid_reg && (!out_valid_reg || result_ready);
    assign item_ready   = !stage_valid_reg || advance;
    assign result_valid = out_valid_reg;
    assign result       = out_reg;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            levels_reg.level12_min <= LEVEL12_MIN_RST;
            levels_reg.level12_max <= LEVEL12_MAX_RST;
            levels_reg.level9_min  <= LEVEL9_MIN_RST;
            levels_reg.level9_max  <= LEVEL9_MAX_RST;
            levels_reg.level6_min  <= LEVEL6_MIN_RST;
            levels_reg.level6_max  <= LEVEL6_MAX_RST;
            ignore_ticks_reg       <= IGNORE_TICKS_RST;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_LEVEL12_MIN:  levels_reg.level12_min <= cfg_data;
                REG_LEVEL12_MAX:  levels_reg.level12_max <= cfg_data;
                REG_LEVEL9_MIN:   levels_reg.level9_min  <= cfg_data;
                REG_LEVEL9_MAX:   levels_reg.level9_max  <= cfg_data;
                REG_LEVEL6_MIN:   levels_reg.level6_min  <= cfg_data;
                REG_LEVEL6_MAX:   levels_reg.level6_max  <= cfg_data;
                REG_IGNORE_TICKS: ignore_ticks_reg       <= cfg_data[TICK_W-1:0];
                default:          ignore_ticks_reg       <= ignore_ticks_reg;
            endcase
        end
    end

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            stage_valid_reg <= 1'b0;
        else if (item_ready)
            stage_valid_reg <= item_valid;
    end

    always_ff @(posedge clk)
    begin
        if (item_valid && item_ready)
            stage_reg <= item;
    end

    cpm_filter u_filter (
        .clk            (clk),
        .rst_n          (rst_n),
        .step           (advance),
        .sample_voltage (stage_reg.sample_voltage),
        .ignore_ticks   (ignore_ticks_reg),
        .clean_voltage  (clean_voltage)
    );

    cpm_classify u_classify (
        .voltage     (clean_voltage),
        .pwm_on      (stage_reg.pwm_on),
        .levels      (levels_reg),
        .pilot_class (pilot_class)
    );

    cpm_fsm u_fsm (
        .clk          (clk),
        .rst_n        (rst_n),
        .step         (advance),
        .pilot_class  (pilot_class),
        .charge_state (charge_state),
        .event_code   (event_code)
    );

    // Gather the result fields
    always_comb
    begin
        out_next.clean_voltage = clean_voltage;
        out_next.pilot_class   = pilot_class;
        out_next.charge_state  = charge_state;
        out_next.event_code    = event_code;
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= 1'b1;
        else if (result_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            out_reg <= out_next;
    end

    // Unknown class always reports an error
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && (result.pilot_class == CLS_UNKNOWN)) |->
        ((result.event_code == EV_ERROR) && (result.charge_state == CHG_ERROR)))
        else $error("unknown class without error report");

    // Charge state stays within its defined codes
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (result.charge_state <= CHG_ERROR))
        else $error("charge state code out of range");

    // Input stalls only when both registers are full and the output is blocked
    assert property (@(posedge clk) disable iff (!rst_n)
        !item_ready |-> (stage_valid_reg && out_valid_reg && !result_ready))
        else $error("input stalled with room in the pipeline");

    // A recovery event always leads to the unplugged or plugged state
    assert property (@(posedge clk) disable iff (!rst_n)
        (advance && (event_code == EV_RECOVERY)) |->
        (charge_state == CHG_UNPLUGGED || charge_state == CHG_PLUGGED))
        else $error("recovery to an unexpected state");

endmodule

`default_nettype wire
